FILE: src/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg: shared types and constants of the piecewise linear interpolator
// Table entry, controller states, divider request and response, field codes.
// ----------------------------------------------------------------------------
package pli_pkg;

  localparam int PTS_W     = 6;
  localparam int IDX_W     = 5;
  localparam int MAG_W     = 32;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int NUM_W     = PROD_W + 1;
  localparam int QUO_W     = 41;
  localparam int DIV_BITS  = 42;
  localparam int DIV_STEP  = 2;
  localparam int DIV_ITERS = DIV_BITS / DIV_STEP;
  localparam int DCNT_W    = $clog2(DIV_ITERS);
  localparam int SUM_W     = QUO_W + 2;

  typedef logic signed [31:0] q16_t;

  typedef struct packed {
    q16_t x;
    q16_t y;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_LAST,
    ST_RD_PEN,
    ST_RD_FIRST,
    ST_SCAN,
    ST_DIFF,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic               start;
    logic [NUM_W-1:0]   num;
    logic [MAG_W-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [QUO_W-1:0]   quo;
  } div_rsp_t;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FLAT = 1'b1;

  localparam logic [QUO_W-1:0] QUO_CAP = {1'b1, {(QUO_W - 1){1'b0}}};
  localparam q16_t Q16_MAX = 32'sh7fff_ffff;
  localparam q16_t Q16_MIN = 32'sh8000_0000;
  localparam logic [PTS_W-1:0] PTS_RESET = 6'd2;

endpackage

FILE: src/pli_ram.sv
// ----------------------------------------------------------------------------
// pli_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/pli_div.sv
// ----------------------------------------------------------------------------
// pli_div: iterative restoring divider, two quotient bits per cycle
// Quotient of a 65-bit numerator by a 32-bit divisor, capped at 2^40.
// ----------------------------------------------------------------------------
module pli_div (
  input  logic              clk,
  input  logic              rst_n,
  input  pli_pkg::div_req_t req,
  output pli_pkg::div_rsp_t rsp
);

  import pli_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [DCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [MAG_W-1:0]    den_r, den_nxt;
  logic [MAG_W-1:0]    rem_r, rem_nxt;
  logic [DIV_BITS-1:0] dvd_r, dvd_nxt;
  logic [DIV_BITS-1:0] quo_r, quo_nxt;
  logic [QUO_W-1:0]    res_r, res_nxt;

  logic [MAG_W:0]      rem_w;
  logic [MAG_W-1:0]    rem_t;
  logic [DIV_BITS-1:0] dvd_t;
  logic [DIV_BITS-1:0] quo_t;
  logic                over;

  // two dependent restoring steps
  always_comb begin
    rem_t = rem_r;
    dvd_t = dvd_r;
    quo_t = quo_r;
    rem_w = '0;
    for (int s = 0; s < DIV_STEP; s++) begin
      rem_w = {rem_t, dvd_t[DIV_BITS-1]};
      dvd_t = {dvd_t[DIV_BITS-2:0], 1'b0};
      if (rem_w >= {1'b0, den_r}) begin
        rem_w = rem_w - {1'b0, den_r};
        quo_t = {quo_t[DIV_BITS-2:0], 1'b1};
      end else begin
        quo_t = {quo_t[DIV_BITS-2:0], 1'b0};
      end
      rem_t = rem_w[MAG_W-1:0];
    end
  end

  assign over = {{(MAG_W - (NUM_W - QUO_W)){1'b0}}, req.num[NUM_W-1:QUO_W]} >= req.den;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    res_nxt  = res_r;
    if (req.start) begin
      if (over) begin
        res_nxt  = QUO_CAP;
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
        cnt_nxt  = '0;
        den_nxt  = req.den;
        rem_nxt  = MAG_W'(req.num[NUM_W-1:DIV_BITS]);
        dvd_nxt  = req.num[DIV_BITS-1:0];
        quo_nxt  = '0;
      end
    end else if (busy_r) begin
      rem_nxt = rem_t;
      dvd_nxt = dvd_t;
      quo_nxt = quo_t;
      cnt_nxt = cnt_r + DCNT_W'(1);
      if (cnt_r == DCNT_W'(DIV_ITERS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt  = (quo_t > DIV_BITS'(QUO_CAP)) ? QUO_CAP : quo_t[QUO_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    res_r <= res_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = res_r;

endmodule

FILE: src/piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator: breakpoint table with Q16.16 interpolation
//
//   channel  | direction | payload
//   in_      | input     | func, entry_index, position, level, extrapolate
//   out_     | output    | interpolated, status (one per query)
//   cfg_     | input     | points_in_use
//
// A query reads the last and second-to-last breakpoints, scans from the first
// when the position lies below the second-to-last, ends after the differences
// on a zero-width interval or the last breakpoint, else multiplies and runs
// the 21-step divider, which stops early at the quotient cap. One query is in
// work at a time; a result waits in the output register while writes and the
// next query are taken. Reset clears control only; table contents are kept.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator #(
  parameter int MAX_POINTS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic [4:0]         in_entry_index,
  input  logic signed [31:0] in_position,
  input  logic signed [31:0] in_level,
  input  logic               in_extrapolate,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_interpolated,
  output logic               out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [5:0]         cfg_points_in_use
);

  import pli_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int CW = (NW > PTS_W) ? NW : PTS_W;

  state_t            state_r, state_nxt;
  logic [PTS_W-1:0]  pts_r;
  logic              out_valid_r, out_valid_nxt;
  q16_t              out_interp_r, out_interp_nxt;
  logic              out_status_r, out_status_nxt;

  q16_t              x_r, x_nxt;
  logic              extra_r, extra_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic [AW-1:0]     i_r, i_nxt;
  q16_t              last_x_r, last_x_nxt;
  entry_t            left_r, left_nxt;
  entry_t            right_r, right_nxt;
  q16_t              yl_r, yl_nxt;
  logic [MAG_W-1:0]  mag_dx_r, mag_dx_nxt;
  logic [MAG_W-1:0]  mag_dy_r, mag_dy_nxt;
  logic [MAG_W-1:0]  mag_ox_r, mag_ox_nxt;
  logic              neg_r, neg_nxt;
  logic              qzero_r, qzero_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  q16_t              res_r, res_nxt;
  logic              status_r, status_nxt;

  logic [CW-1:0]     pts_ext;
  logic [CW-1:0]     n_now;
  logic [CW-1:0]     idx_ext;
  logic [CW-1:0]     addr_w;
  logic [AW-1:0]     raddr;
  logic [ENTRY_W-1:0] rd_raw;
  entry_t            rd_entry;
  entry_t            wr_entry;
  logic              in_xfer;
  logic              wr_en;
  logic              scan_more;
  logic              out_load;

  q16_t              yl_c, yr_c;
  logic signed [MAG_W:0] dx_c, dy_c, ox_c;
  logic [MAG_W:0]    abs_dx, abs_dy, abs_ox;
  logic              last_hit, dx_zero;
  logic [QUO_W-1:0]  q_eff;
  logic signed [SUM_W-1:0] yl_ext, q_ext, sum_c;
  q16_t              sat_c;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // handshakes and table write
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign idx_ext   = CW'(in_entry_index);
  assign wr_en     = in_xfer && (in_func == FUNC_WRITE) && (idx_ext < CW'(MAX_POINTS));
  assign wr_entry  = '{x: in_position, y: in_level};
  assign rd_entry  = rd_raw;

  assign pts_ext = CW'(pts_r);
  assign n_now   = (pts_ext < CW'(2)) ? CW'(2) :
                   ((pts_ext > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : pts_ext);

  assign scan_more = (CW'(i_r) < (n_r - CW'(2))) && (x_r > rd_entry.x);

  pli_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx_ext[AW-1:0]),
    .wdata (wr_entry),
    .raddr (raddr),
    .rdata (rd_raw)
  );

  // interval arithmetic
  always_comb begin
    yl_c = left_r.y;
    yr_c = right_r.y;
    if (!extra_r) begin
      if (x_r < left_r.x) begin
        yr_c = yl_c;
      end
      if (x_r > right_r.x) begin
        yl_c = yr_c;
      end
    end
    dx_c     = {right_r.x[31], right_r.x} - {left_r.x[31], left_r.x};
    dy_c     = {yr_c[31], yr_c} - {yl_c[31], yl_c};
    ox_c     = {x_r[31], x_r} - {left_r.x[31], left_r.x};
    abs_dx   = dx_c[MAG_W] ? (MAG_W + 1)'(-dx_c) : dx_c;
    abs_dy   = dy_c[MAG_W] ? (MAG_W + 1)'(-dy_c) : dy_c;
    abs_ox   = ox_c[MAG_W] ? (MAG_W + 1)'(-ox_c) : ox_c;
    last_hit = (x_r == last_x_r);
    dx_zero  = (dx_c == '0);
  end

  // final sum with saturation
  always_comb begin
    q_eff  = qzero_r ? '0 : div_rsp.quo;
    yl_ext = SUM_W'(yl_r);
    q_ext  = SUM_W'(q_eff);
    sum_c  = neg_r ? (yl_ext - q_ext) : (yl_ext + q_ext);
    if (sum_c[SUM_W-1:31] != {(SUM_W - 31){sum_c[SUM_W-1]}}) begin
      sat_c = sum_c[SUM_W-1] ? Q16_MIN : Q16_MAX;
    end else begin
      sat_c = sum_c[31:0];
    end
  end

  assign div_req.start = (state_r == ST_DIV_GO);
  assign div_req.num   = {1'b0, prod_r} + NUM_W'(mag_dx_r >> 1);
  assign div_req.den   = mag_dx_r;

  pli_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_func == FUNC_QUERY)) begin
          state_nxt = ST_RD_LAST;
        end
      end
      ST_RD_LAST:  state_nxt = ST_RD_PEN;
      ST_RD_PEN: begin
        state_nxt = (x_r >= rd_entry.x) ? ST_DIFF : ST_RD_FIRST;
      end
      ST_RD_FIRST: state_nxt = ST_SCAN;
      ST_SCAN: begin
        state_nxt = scan_more ? ST_SCAN : ST_DIFF;
      end
      ST_DIFF: begin
        state_nxt = (last_hit || dx_zero) ? ST_OUT : ST_MUL;
      end
      ST_MUL:      state_nxt = ST_DIV_GO;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  // datapath and read address
  always_comb begin
    x_nxt          = x_r;
    extra_nxt      = extra_r;
    n_nxt          = n_r;
    i_nxt          = i_r;
    last_x_nxt     = last_x_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    yl_nxt         = yl_r;
    mag_dx_nxt     = mag_dx_r;
    mag_dy_nxt     = mag_dy_r;
    mag_ox_nxt     = mag_ox_r;
    neg_nxt        = neg_r;
    qzero_nxt      = qzero_r;
    prod_nxt       = prod_r;
    res_nxt        = res_r;
    status_nxt     = status_r;
    out_interp_nxt = out_interp_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r;
    addr_w         = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        addr_w    = n_now - CW'(1);
        x_nxt     = in_position;
        extra_nxt = in_extrapolate;
        n_nxt     = n_now;
      end
      ST_RD_LAST: begin
        addr_w     = n_r - CW'(2);
        last_x_nxt = rd_entry.x;
        right_nxt  = rd_entry;
      end
      ST_RD_PEN: begin
        addr_w   = '0;
        left_nxt = rd_entry;
      end
      ST_RD_FIRST: begin
        addr_w   = CW'(1);
        left_nxt = rd_entry;
        i_nxt    = '0;
      end
      ST_SCAN: begin
        addr_w = CW'(i_r) + CW'(2);
        if (scan_more) begin
          left_nxt = rd_entry;
          i_nxt    = i_r + AW'(1);
        end else begin
          right_nxt = rd_entry;
        end
      end
      ST_DIFF: begin
        yl_nxt     = yl_c;
        mag_dx_nxt = abs_dx[MAG_W-1:0];
        mag_dy_nxt = abs_dy[MAG_W-1:0];
        mag_ox_nxt = abs_ox[MAG_W-1:0];
        neg_nxt    = dy_c[MAG_W] ^ ox_c[MAG_W] ^ dx_c[MAG_W];
        qzero_nxt  = (dy_c == '0) || (ox_c == '0);
        if (last_hit) begin
          res_nxt    = '0;
          status_nxt = STATUS_OK;
        end else if (dx_zero) begin
          res_nxt    = yl_c;
          status_nxt = STATUS_FLAT;
        end
      end
      ST_MUL: begin
        prod_nxt = mag_dy_r * mag_ox_r;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          res_nxt    = sat_c;
          status_nxt = STATUS_OK;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_interp_nxt = res_r;
          out_status_nxt = status_r;
        end
      end
      default: begin
        addr_w = '0;
      end
    endcase
    raddr = addr_w[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pts_r       <= PTS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        pts_r <= cfg_points_in_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    extra_r      <= extra_nxt;
    n_r          <= n_nxt;
    i_r          <= i_nxt;
    last_x_r     <= last_x_nxt;
    left_r       <= left_nxt;
    right_r      <= right_nxt;
    yl_r         <= yl_nxt;
    mag_dx_r     <= mag_dx_nxt;
    mag_dy_r     <= mag_dy_nxt;
    mag_ox_r     <= mag_ox_nxt;
    neg_r        <= neg_nxt;
    qzero_r      <= qzero_nxt;
    prod_r       <= prod_nxt;
    res_r        <= res_nxt;
    status_r     <= status_nxt;
    out_interp_r <= out_interp_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_interpolated = out_interp_r;
  assign out_status       = out_status_r;

endmodule

FILE: src/pli_checker.sv
// ----------------------------------------------------------------------------
// pli_props: port-level checks for the piecewise linear interpolator
// Reset, query occupancy, write turnaround and result hold under stall.
// ----------------------------------------------------------------------------
module pli_props (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_func,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_interpolated,
  input logic               out_status
);

  import pli_pkg::*;

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_QUERY) |=> !in_ready)
    else $error("input taken while a query is in work");

  a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_WRITE) |=> in_ready)
    else $error("table write did not finish in one cycle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_interpolated) && $stable(out_status))
    else $error("result changed before transfer");

endmodule

bind piecewise_linear_interpolator pli_props u_pli_props (.*);

FILE: sim/pli_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pli_checker: scoreboard for the piecewise linear interpolator
// Follows breakpoint writes and point-count updates from the observed
// transfers, predicts the level and status of every query in Q16.16 and
// compares them in order with the results that leave the block.
// ----------------------------------------------------------------------------
module pli_checker #(
  parameter int MAX_PTS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_func,
  input  logic [4:0]         in_entry_index,
  input  logic signed [31:0] in_position,
  input  logic signed [31:0] in_level,
  input  logic               in_extrapolate,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_interpolated,
  input  logic               out_status,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [5:0]         cfg_points_in_use,
  output int                 fail_count,
  output int                 pending,
  output int                 results_checked,
  output int                 flat_results,
  output int                 writes_seen
);
  import pli_pkg::*;

  localparam logic [127:0] LEVEL_CAP = 128'd1 << 40;

  typedef struct packed {
    q16_t position;
    logic extrapolate;
    q16_t level;
    logic status;
  } level_exp_t;

  q16_t       bp_x [MAX_PTS];
  q16_t       bp_y [MAX_PTS];
  logic [5:0] pts;
  level_exp_t level_q [$];

  function automatic void predict_level(input q16_t x, input logic ext,
                                        output q16_t lvl, output logic st);
    int           n;
    int           i;
    longint       xv, xl, yl, xr, yr, dx, dy, ox, mdx, mdy, mox, acc;
    logic [127:0] quo;
    logic         neg;
    n = int'(pts);
    if (n < 2) n = 2;
    if (n > MAX_PTS) n = MAX_PTS;
    i = 0;
    if (x >= bp_x[n - 2]) begin
      i = n - 2;
    end else begin
      while (i < n - 2 && x > bp_x[i + 1]) i++;
    end
    xv = x;
    xl = bp_x[i];
    yl = bp_y[i];
    xr = bp_x[i + 1];
    yr = bp_y[i + 1];
    st = STATUS_OK;
    // clamp to the end levels outside the interval
    if (!ext) begin
      if (xv < xl) yr = yl;
      if (xv > xr) yl = yr;
    end
    if (x == bp_x[n - 1]) begin
      lvl = '0;
    end else begin
      dx = xr - xl;
      if (dx == 0) begin
        lvl = q16_t'(yl);
        st  = STATUS_FLAT;
      end else begin
        dy  = yr - yl;
        ox  = xv - xl;
        neg = ((dy < 0) != (ox < 0)) != (dx < 0);
        mdx = (dx < 0) ? -dx : dx;
        mdy = (dy < 0) ? -dy : dy;
        mox = (ox < 0) ? -ox : ox;
        // exact product, rounded half away from zero
        quo = (128'(mdy) * 128'(mox) + 128'(mdx >> 1)) / 128'(mdx);
        if (dy == 0 || ox == 0) begin
          quo = '0;
        end else if (quo > LEVEL_CAP) begin
          quo = LEVEL_CAP;
        end
        acc = neg ? yl - longint'(quo[63:0]) : yl + longint'(quo[63:0]);
        if (acc > longint'(Q16_MAX)) acc = Q16_MAX;
        if (acc < longint'(Q16_MIN)) acc = Q16_MIN;
        lvl = q16_t'(acc);
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    level_exp_t want;
    q16_t       lvl;
    logic       st;
    if (!rst_n) begin
      pts = PTS_RESET;
      level_q.delete();
      fail_count      = 0;
      pending         = 0;
      results_checked = 0;
      flat_results    = 0;
      writes_seen     = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (level_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result level %0d status %b", $realtime,
                     out_interpolated, out_status);
        end else begin
          want = level_q.pop_front();
          results_checked++;
          if (out_interpolated !== want.level || out_status !== want.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: position %0d extrapolate %b: expected level %0d status %b, got level %0d status %b",
                       $realtime, want.position, want.extrapolate, want.level,
                       want.status, out_interpolated, out_status);
          end
        end
      end
      if (cfg_valid && cfg_ready) pts = cfg_points_in_use;
      if (in_valid && in_ready) begin
        if (in_func == FUNC_WRITE) begin
          if (in_entry_index < MAX_PTS) begin
            bp_x[in_entry_index] = in_position;
            bp_y[in_entry_index] = in_level;
          end
          writes_seen++;
        end else begin
          predict_level(in_position, in_extrapolate, lvl, st);
          if (st == STATUS_FLAT) flat_results++;
          want.position    = in_position;
          want.extrapolate = in_extrapolate;
          want.level       = lvl;
          want.status      = st;
          level_q.push_back(want);
        end
      end
      pending = level_q.size();
    end
  end

endmodule

FILE: sim/piecewise_linear_interpolator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_tb: top of the interpolator testbench
// Loads breakpoint tables of many sizes and shapes, sends queries around and
// between the breakpoints with random idling on both channels, and leaves
// prediction and comparison to the scoreboard beside the block.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_tb;
  import pli_pkg::*;

  localparam int MAX_PTS       = 32;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 144;
  localparam int SETTLE_CYCLES = 80;
  localparam int IDLE_LIMIT    = 4000;

  logic       clk               = 1'b0;
  logic       rst_n             = 1'b0;
  logic       in_valid          = 1'b0;
  logic       in_ready;
  logic       in_func           = FUNC_WRITE;
  logic [4:0] in_entry_index    = '0;
  q16_t       in_position       = '0;
  q16_t       in_level          = '0;
  logic       in_extrapolate    = 1'b0;
  logic       out_valid;
  logic       out_ready         = 1'b1;
  q16_t       out_interpolated;
  logic       out_status;
  logic       cfg_valid         = 1'b0;
  logic       cfg_ready;
  logic [5:0] cfg_points_in_use = PTS_RESET;

  int   fail_count, pending, results_checked, flat_results, writes_seen;
  int   gap_pct     = 20;
  int   stall_pct   = 20;
  bit   quiet       = 1'b0;
  int   idle_cycles = 0;
  q16_t tbl_x [MAX_PTS];

  piecewise_linear_interpolator #(
    .MAX_POINTS(MAX_PTS)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_entry_index   (in_entry_index),
    .in_position      (in_position),
    .in_level         (in_level),
    .in_extrapolate   (in_extrapolate),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_interpolated (out_interpolated),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_points_in_use(cfg_points_in_use)
  );

  pli_checker #(
    .MAX_PTS(MAX_PTS)
  ) level_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_entry_index   (in_entry_index),
    .in_position      (in_position),
    .in_level         (in_level),
    .in_extrapolate   (in_extrapolate),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_interpolated (out_interpolated),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_points_in_use(cfg_points_in_use),
    .fail_count       (fail_count),
    .pending          (pending),
    .results_checked  (results_checked),
    .flat_results     (flat_results),
    .writes_seen      (writes_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(input logic func, input logic [4:0] idx, input q16_t pos,
                           input q16_t lvl, input logic ext);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= func;
    in_entry_index <= idx;
    in_position    <= pos;
    in_level       <= lvl;
    in_extrapolate <= ext;
    do @(posedge clk); while (!in_ready);
    if (func == FUNC_WRITE) tbl_x[idx] = pos;
  endtask

  task automatic put_point(input logic [4:0] idx, input q16_t x, input q16_t y);
    send_item(FUNC_WRITE, idx, x, y, 1'($urandom_range(0, 1)));
  endtask

  task automatic ask(input q16_t pos, input logic ext);
    send_item(FUNC_QUERY, 5'($urandom_range(0, 31)), pos, q16_t'($urandom), ext);
  endtask

  // hold the sender until every expected result has come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [5:0] plan [PHASES];
    int         n_eff, mode, j;
    longint     xa, step_max, lo, span;
    q16_t       pos, yv;
    plan = '{6'd32, 6'd0, 6'd7, 6'd63, 6'd1, 6'd3, 6'd33, 6'd16, 6'd24, 6'd2,
             6'd12, 6'd32};
    plan[8]  = 6'($urandom_range(0, 63));
    plan[10] = 6'($urandom_range(0, 63));
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // two-point table at the reset point count
    put_point(5'd0, -32'sd65536, Q16_MIN);
    put_point(5'd1, 32'sh0002_0000, Q16_MAX);
    ask(-32'sd65536, 1'b0);
    ask(32'sh0002_0000, 1'b0);
    ask(Q16_MIN, 1'b0);
    ask(Q16_MIN, 1'b1);
    ask(Q16_MAX, 1'b0);
    ask(Q16_MAX, 1'b1);
    ask(32'sd0, 1'b0);
    ask(32'sh0000_8000, 1'b1);
    // zero-width interval, and the last breakpoint taking priority
    put_point(5'd1, -32'sd65536, 32'sd12345);
    ask(32'sd5, 1'b0);
    ask(Q16_MIN, 1'b1);
    ask(-32'sd65536, 1'b0);
    // flat level
    put_point(5'd1, 32'sd65536, Q16_MIN);
    ask(32'sd0, 1'b1);
    // steep interval, quotient cap and saturation
    put_point(5'd0, 32'sd0, 32'sd0);
    put_point(5'd1, 32'sd1, Q16_MAX);
    ask(Q16_MAX, 1'b1);
    ask(Q16_MIN, 1'b1);
    ask(Q16_MIN, 1'b0);
    // rounding ties on both signs
    put_point(5'd1, 32'sd2, 32'sd1);
    ask(32'sd1, 1'b0);
    put_point(5'd1, 32'sd2, -32'sd1);
    ask(32'sd1, 1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      cfg_valid         <= 1'b1;
      cfg_points_in_use <= plan[ph];
      do @(posedge clk); while (!cfg_ready);
      cfg_valid <= 1'b0;

      quiet     = (ph == PHASES - 1);
      gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
      stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
      n_eff = (plan[ph] < 2) ? 2 : ((plan[ph] > MAX_PTS) ? MAX_PTS : int'(plan[ph]));

      // table shape: wide ascending, narrow ascending, with repeats, or unordered
      mode = $urandom_range(0, 5);
      if (mode <= 1) begin
        step_max = (64'd3 << 30) / n_eff;
        xa = -(longint'(1) << 31);
        if ($urandom_range(0, 3) != 0) xa = xa + longint'($urandom_range(0, 1 << 30));
      end else begin
        step_max = 64'd131072;
        xa = -(longint'(n_eff) * 32768) + longint'($urandom_range(0, 65535));
      end
      for (int k = 0; k < n_eff; k++) begin
        if (mode == 5) begin
          pos = q16_t'($urandom);
        end else begin
          if (k > 0) begin
            if (mode == 4 && $urandom_range(0, 2) == 0) xa = xa;
            else xa = xa + longint'($urandom_range(1, 32'(step_max)));
          end
          if (xa > longint'(Q16_MAX)) xa = Q16_MAX;
          pos = q16_t'(xa);
        end
        case ($urandom_range(0, 7))
          0:       yv = Q16_MAX;
          1:       yv = Q16_MIN;
          2, 3, 4: yv = q16_t'($urandom_range(0, 1 << 20)) - 32'sd524288;
          default: yv = q16_t'($urandom);
        endcase
        put_point(5'(k), pos, yv);
      end

      for (int k = n_eff; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          put_point(5'($urandom_range(0, 31)), q16_t'($urandom), q16_t'($urandom));
        end else begin
          j = $urandom_range(0, n_eff - 1);
          case ($urandom_range(0, 9))
            0, 1: pos = q16_t'($urandom);
            2:    pos = tbl_x[j];
            3:    pos = ($urandom_range(0, 1) == 1) ? tbl_x[j] + 32'sd1 : tbl_x[j] - 32'sd1;
            4, 5, 6: begin
              if (j == n_eff - 1) j--;
              lo   = tbl_x[j];
              span = longint'(tbl_x[j + 1]) - lo;
              pos  = (span > 0) ? q16_t'(lo + longint'($urandom) % (span + 1)) : tbl_x[j];
            end
            7:       pos = tbl_x[0] - q16_t'($urandom_range(1, 1 << 20));
            8:       pos = tbl_x[n_eff - 1] + q16_t'($urandom_range(1, 1 << 20));
            default: pos = tbl_x[n_eff - 1];
          endcase
          ask(pos, 1'($urandom_range(0, 1)));
        end
      end
    end

    settle();
    $display("covered %0d breakpoint writes and %0d checked queries, %0d on zero-width intervals",
             writes_seen, results_checked, flat_results);
    $display("point counts swept over %0d settings from below 2 to above %0d, with clamping and extrapolation",
             PHASES, MAX_PTS);
    if (fail_count == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
